/* rtl/vrf_pkg.sv */
// ----------------------------------------------------------------------------
// vrf_pkg
// Shared types and codes for the video register file: operation codes,
// register numbers, the input item and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

package vrf_pkg;

    // Operation carried by one input transaction
    typedef enum logic [2:0] {
        OP_READ        = 3'd0,
        OP_WRITE       = 3'd1,
        OP_MEM_RETURN  = 3'd2,
        OP_FRAME_START = 3'd3,
        OP_HBLANK      = 3'd4,
        OP_VBLANK_SET  = 3'd5,
        OP_VBLANK_CLR  = 3'd6,
        OP_SPRITE_HIT  = 3'd7
    } vrf_op_t;

    // CPU-visible register numbers
    localparam logic [2:0] REG_CONTROL     = 3'd0;
    localparam logic [2:0] REG_MASK        = 3'd1;
    localparam logic [2:0] REG_STATUS      = 3'd2;
    localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
    localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL      = 3'd5;
    localparam logic [2:0] REG_ADDRESS     = 3'd6;
    localparam logic [2:0] REG_DATA        = 3'd7;

    // Address space landmarks
    localparam logic [13:0] PALETTE_BASE   = 14'h3f00;
    localparam logic [13:0] NAMETABLE_BASE = 14'h2000;
    localparam logic [4:0]  LAST_ROW       = 5'd30;

    // Status bits
    localparam int unsigned STAT_VBLANK = 7;
    localparam int unsigned STAT_HIT    = 6;

    typedef struct packed {
        vrf_op_t     op;
        logic [2:0]  reg_index;
        logic [7:0]  write_data;
        logic [7:0]  mem_data;
        logic [2:0]  line_count;
    } vrf_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [13:0] mem_addr;
        logic        mem_read;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic [2:0]  fine_scroll_x;
        logic [14:0] current_vram_address;
    } vrf_result_t;

endpackage

`default_nettype wire

/* rtl/vrf_ram.sv */
// ----------------------------------------------------------------------------
// vrf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/vrf_core.sv */
// ----------------------------------------------------------------------------
// vrf_core
// Register state and update logic: decodes one item, forms its result and
// commits the new state when the item retires.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_core
    import vrf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire vrf_item_t   item,
    input  wire logic        advance,
    output vrf_result_t      result
);

    // State
    logic        pattern_writable_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  sprite_addr_reg, sprite_addr_next;
    logic [14:0] vaddr_reg, vaddr_next;
    logic [14:0] taddr_reg, taddr_next;
    logic        second_reg, second_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic [5:0]  palette_reg [32];
    logic [255:0] sprite_valid_reg;
    logic        sprite_valid_q_reg;

    // Combinational helpers
    logic [13:0] step_addr;
    logic [14:0] step_sum;
    logic [4:0]  pal_idx;
    logic        pal_we;
    logic        spr_we;
    logic [7:0]  spr_raddr;
    logic [7:0]  spr_q;
    logic [7:0]  spr_data;
    logic [15:0] hsum;
    logic [14:0] haddr;
    logic [4:0]  hrow;
    logic [14:0] hblank_addr;

    // Data port address and its increment of 1 or 32
    assign step_addr = vaddr_reg[13:0];
    assign step_sum  = {1'b0, step_addr} + (control_reg[2] ? 15'd32 : 15'd1);

    // Palette mirroring: entries with low two bits zero drop bit 4
    always_comb begin
        pal_idx = step_addr[4:0];
        if (step_addr[1:0] == 2'b00) begin
            pal_idx[4] = 1'b0;
        end
    end

    // Sprite data: unwritten entries read zero, byte 2 of 4 loses bits 4:2
    always_comb begin
        spr_data = sprite_valid_q_reg ? spr_q : 8'h00;
        if (sprite_addr_reg[1:0] == 2'b10) begin
            spr_data = spr_data & 8'he3;
        end
    end

    // Hblank: add lines to fine Y, carry into coarse Y with row 30 wrap
    always_comb begin
        hsum  = {1'b0, vaddr_reg} + {1'b0, item.line_count, 12'h000};
        haddr = hsum[14:0];
        hrow  = haddr[9:5] + 5'd1;
        if (hsum[15]) begin
            if (hrow == LAST_ROW) begin
                hblank_addr = {haddr[14:12], ~haddr[11], haddr[10], 5'd0, haddr[4:0]};
            end else begin
                hblank_addr = {haddr[14:10], hrow, haddr[4:0]};
            end
        end else begin
            hblank_addr = haddr;
        end
    end

    // Decode the item and form next state and result
    always_comb begin
        control_next     = control_reg;
        mask_next        = mask_reg;
        status_next      = status_reg;
        sprite_addr_next = sprite_addr_reg;
        vaddr_next       = vaddr_reg;
        taddr_next       = taddr_reg;
        second_next      = second_reg;
        fine_x_next      = fine_x_reg;
        rbuf_next        = rbuf_reg;
        pal_we           = 1'b0;
        spr_we           = 1'b0;
        result           = '0;

        case (item.op)
            OP_READ: begin
                case (item.reg_index)
                    REG_STATUS: begin
                        result.read_data        = status_reg;
                        status_next[STAT_VBLANK] = 1'b0;
                        second_next             = 1'b0;
                    end
                    REG_SPRITE_DATA: begin
                        result.read_data = spr_data;
                    end
                    REG_DATA: begin
                        vaddr_next         = step_sum;
                        result.mem_addr    = step_addr;
                        result.mem_read    = 1'b1;
                        result.read_data   = (step_addr >= PALETTE_BASE) ?
                                             {2'b00, palette_reg[pal_idx]} : rbuf_reg;
                    end
                    default: begin
                    end
                endcase
            end
            OP_WRITE: begin
                case (item.reg_index)
                    REG_CONTROL: begin
                        taddr_next   = {taddr_reg[14:12], item.write_data[1:0],
                                        taddr_reg[9:0]};
                        control_next = item.write_data;
                    end
                    REG_MASK: begin
                        mask_next = item.write_data;
                    end
                    REG_SPRITE_ADDR: begin
                        sprite_addr_next = item.write_data;
                    end
                    REG_SPRITE_DATA: begin
                        spr_we           = 1'b1;
                        sprite_addr_next = sprite_addr_reg + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (second_reg) begin
                            taddr_next = {item.write_data[2:0], taddr_reg[11:10],
                                          item.write_data[7:3], taddr_reg[4:0]};
                        end else begin
                            fine_x_next = item.write_data[2:0];
                            taddr_next  = {taddr_reg[14:5], item.write_data[7:3]};
                        end
                        second_next = ~second_reg;
                    end
                    REG_ADDRESS: begin
                        if (second_reg) begin
                            taddr_next = {taddr_reg[14:8], item.write_data};
                            vaddr_next = {taddr_reg[14:8], item.write_data};
                        end else begin
                            taddr_next = {1'b0, item.write_data[5:0], taddr_reg[7:0]};
                        end
                        second_next = ~second_reg;
                    end
                    REG_DATA: begin
                        vaddr_next = step_sum;
                        if (step_addr >= PALETTE_BASE) begin
                            pal_we = 1'b1;
                        end else if (step_addr >= NAMETABLE_BASE || pattern_writable_reg) begin
                            result.mem_addr       = step_addr;
                            result.mem_write      = 1'b1;
                            result.mem_write_data = item.write_data;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_MEM_RETURN: begin
                rbuf_next = item.mem_data;
            end
            OP_FRAME_START: begin
                if (mask_reg[3]) begin
                    vaddr_next = taddr_reg;
                end
            end
            OP_HBLANK: begin
                if (mask_reg[3]) begin
                    vaddr_next = hblank_addr;
                end
            end
            OP_VBLANK_SET: begin
                status_next[STAT_VBLANK] = 1'b1;
            end
            OP_VBLANK_CLR: begin
                status_next[STAT_VBLANK] = 1'b0;
                status_next[STAT_HIT]    = 1'b0;
            end
            OP_SPRITE_HIT: begin
                status_next[STAT_HIT] = 1'b1;
            end
            default: begin
            end
        endcase

        result.fine_scroll_x        = fine_x_next;
        result.current_vram_address = vaddr_next;
    end

    // Commit state when the item retires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg     <= '0;
            mask_reg        <= '0;
            status_reg      <= '0;
            sprite_addr_reg <= '0;
            vaddr_reg       <= '0;
            taddr_reg       <= '0;
            second_reg      <= 1'b0;
            fine_x_reg      <= '0;
            rbuf_reg        <= '0;
        end else if (advance) begin
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            status_reg      <= status_next;
            sprite_addr_reg <= sprite_addr_next;
            vaddr_reg       <= vaddr_next;
            taddr_reg       <= taddr_next;
            second_reg      <= second_next;
            fine_x_reg      <= fine_x_next;
            rbuf_reg        <= rbuf_next;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_writable_reg <= 1'b0;
        end else if (cfg_we) begin
            pattern_writable_reg <= cfg_wdata;
        end
    end

    // Palette entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) begin
                palette_reg[i] <= '0;
            end
        end else if (advance && pal_we) begin
            palette_reg[pal_idx] <= item.write_data[5:0];
        end
    end

    // Look up the sprite entry for the address the next item will see
    assign spr_raddr = advance ? sprite_addr_next : sprite_addr_reg;

    // Sprite entry valid bits, looked up alongside the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sprite_valid_reg   <= '0;
            sprite_valid_q_reg <= 1'b0;
        end else begin
            if (advance && spr_we) begin
                sprite_valid_reg[sprite_addr_reg] <= 1'b1;
            end
            sprite_valid_q_reg <= sprite_valid_reg[spr_raddr];
        end
    end

    vrf_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_sprite_ram (
        .clk   (aclk),
        .we    (advance && spr_we),
        .waddr (sprite_addr_reg),
        .wdata (item.write_data),
        .raddr (spr_raddr),
        .rdata (spr_q)
    );

endmodule

`default_nettype wire

/* rtl/video_register_file_top.sv */
// ----------------------------------------------------------------------------
// video_register_file_top
// CPU-side video register file: input register, update logic and result
// register on stream channels.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tuser op, s_tdata register fields
//  m_       out        m_tvalid/m_tready  m_tdata one result per transaction
//  cfg_     in         cfg_we             cfg_wdata pattern_ram_writable
//
//  One transaction accepted per cycle while the result channel does not
//  stall; it is captured in the input register, and its result is
//  captured in the result register once that register is free.
//  The update logic is combinational; the sprite RAM's registered read
//  port is addressed ahead, with the address the next item will see.
//  Reset is synchronous, active low; it clears all core state including
//  palette and sprite entries (per-entry valid bits), with no clearing pass.
//  A stalled result holds in the result register while one more transaction
//  waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module video_register_file_top
    import vrf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // operation[2:0]
    input  wire logic [23:0] s_tdata,   // reg_index[2:0], write_data[10:3],
                                        // mem_data[18:11], line_count[21:19]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // read_data[7:0], mem_addr[21:8],
                                        // mem_read[22], mem_write[23],
                                        // mem_write_data[31:24],
                                        // fine_scroll_x[34:32],
                                        // current_vram_address[49:35]
);

    logic        s1_valid_reg;
    vrf_item_t   item_reg;
    logic        out_valid_reg;
    vrf_result_t out_reg;
    vrf_result_t result;
    logic        advance;

    // Retire the held item when the result register is free
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op         <= vrf_op_t'(s_tuser[2:0]);
            item_reg.reg_index  <= s_tdata[2:0];
            item_reg.write_data <= s_tdata[10:3];
            item_reg.mem_data   <= s_tdata[18:11];
            item_reg.line_count <= s_tdata[21:19];
        end
    end

    vrf_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_reg),
        .advance   (advance),
        .result    (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.current_vram_address,
                       out_reg.fine_scroll_x,
                       out_reg.mem_write_data,
                       out_reg.mem_write,
                       out_reg.mem_read,
                       out_reg.mem_addr,
                       out_reg.read_data};

    // A result never asks for both a memory read and a memory write
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.mem_read && out_reg.mem_write))
        else $error("result issues read and write together");

    // A held item that cannot retire stays held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("held item lost");

    // An accepted transaction lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted transaction dropped");

    // A taken result with nothing behind it empties the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !s1_valid_reg) |=> !m_tvalid)
        else $error("result repeated");

endmodule

`default_nettype wire
